// ===== sv/snor_pkg.sv =====
package snor_pkg;

  localparam int unsigned PageBytesDef   = 256;
  localparam int unsigned SectorBytesDef = 4096;
  localparam int unsigned AddrBitsDef    = 24;
  localparam int unsigned TickBitsDef    = 12;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINK   = 2'd0,
    CFG_PGM_TO = 2'd1,
    CFG_ERS_TO = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_PGM   = 3'd1,
    CMD_ERASE = 3'd2,
    CMD_ID    = 3'd3,
    CMD_BYTE  = 3'd4,
    CMD_REPLY = 3'd5,
    CMD_TICK  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_XFER  = 3'd0,
    KIND_CSREL = 3'd1,
    KIND_RDATA = 3'd2,
    KIND_DREQ  = 3'd3,
    KIND_DONE  = 3'd4
  } kind_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_SE    = 8'h20;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_RDID  = 8'h9F;
  localparam logic [7:0] OP_DUMMY = 8'hFF;
  localparam logic [7:0] DENSITY_4MIB = 8'h16;
  localparam logic [22:0] CAPACITY_4MIB = 23'h400000;

  typedef enum logic [10:0] {
    PH_IDLE      = 11'b00000000001,
    PH_READ_HDR  = 11'b00000000010,
    PH_READ_DATA = 11'b00000000100,
    PH_ID        = 11'b00000001000,
    PH_WREN      = 11'b00000010000,
    PH_PP_HDR    = 11'b00000100000,
    PH_PP_WAIT   = 11'b00001000000,
    PH_PP_DATA   = 11'b00010000000,
    PH_ER_HDR    = 11'b00100000000,
    PH_POLL_CMD  = 11'b01000000000,
    PH_POLL_STAT = 11'b10000000000
  } phase_e;

  typedef enum logic [1:0] {
    OPN_READ  = 2'd0,
    OPN_PGM   = 2'd1,
    OPN_ERASE = 2'd2,
    OPN_ID    = 2'd3
  } opn_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic [7:0]  miso_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  mosi_byte;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [23:0] id_value;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  r0;
    out_word_t  r1;
    out_word_t  r2;
  } res_set_t;

endpackage

// ===== sv/snor_core.sv =====
module snor_core #(
  parameter int unsigned PageBytes   = snor_pkg::PageBytesDef,
  parameter int unsigned SectorBytes = snor_pkg::SectorBytesDef,
  parameter int unsigned AddrBits    = snor_pkg::AddrBitsDef,
  parameter int unsigned TickBits    = snor_pkg::TickBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               step_i,
  input  snor_pkg::in_word_t item_i,
  output snor_pkg::res_set_t res_o
);
  import snor_pkg::*;

  localparam int unsigned PgW = $clog2(PageBytes + 1);
  localparam int unsigned PoW = $clog2(PageBytes);
  localparam int unsigned SeW = $clog2(SectorBytes);
  localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

  logic        link_q;
  logic [11:0] pgm_to_q, ers_to_q;
  phase_e      ph_q, ph_d;
  opn_e        op_q, op_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [15:0] rem_q, rem_d;
  logic [PgW-1:0] pgl_q, pgl_d;
  logic [2:0]  fi_q, fi_d;
  logic [TickBits-1:0] tk_q, tk_d;
  logic [23:0] ids_q, ids_d;
  logic [22:0] cap_q, cap_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q   <= 1'b0;
      pgm_to_q <= 12'd500;
      ers_to_q <= 12'd3000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINK:   link_q   <= cfg_data_i[0];
        CFG_PGM_TO: pgm_to_q <= cfg_data_i;
        CFG_ERS_TO: ers_to_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; op_q <= OPN_READ; addr_q <= '0; rem_q <= '0;
      pgl_q <= '0; fi_q <= '0; tk_q <= '0; ids_q <= '0; cap_q <= '0;
    end else if (step_i) begin
      ph_q <= ph_d; op_q <= op_d; addr_q <= addr_d; rem_q <= rem_d;
      pgl_q <= pgl_d; fi_q <= fi_d; tk_q <= tk_d; ids_q <= ids_d; cap_q <= cap_d;
    end
  end

  function automatic out_word_t mk(logic [2:0] k, logic [7:0] m, logic [7:0] r,
                                   logic [1:0] s, logic [23:0] id);
    out_word_t w;
    w.kind = k; w.mosi_byte = m; w.read_byte = r; w.status = s; w.id_value = id;
    w.last = 1'b0;
    return w;
  endfunction

  logic [AddrBits-1:0] a_in, aligned, cur_p1;
  logic [23:0] a24, cur24;
  logic [24:0] chk_a, chk_len;
  logic        rng_ok;
  logic [PgW-1:0] chunk_pg, pgl_m1;
  logic [15:0] rem_m1;
  logic [11:0] lim12;
  logic [TickBits-1:0] limit;
  logic [2:0]  fi_p1;
  logic [7:0]  abyte;
  logic [23:0] ids_sh;

  always_comb begin
    a_in    = item_i.address[AddrBits-1:0];
    aligned = {a_in[AddrBits-1:SeW], {SeW{1'b0}}};
    a24     = 24'(a_in);
    cur24   = 24'(addr_q);
    cur_p1  = addr_q + 1'b1;
    // range check base and length
    chk_a   = (item_i.command == CMD_ERASE) ? 25'(aligned) : 25'(a24);
    chk_len = (item_i.command == CMD_ERASE) ? 25'(SectorBytes) : 25'(item_i.length);
    rng_ok  = link_q && (cap_q != '0) && (chk_a <= 25'(cap_q))
              && (chk_len <= 25'(cap_q) - chk_a);
    fi_p1   = fi_q + 3'd1;
    case (fi_p1[1:0])
      2'd1:    abyte = cur24[23:16];
      2'd2:    abyte = cur24[15:8];
      default: abyte = cur24[7:0];
    endcase
    rem_m1  = rem_q - 16'd1;
    pgl_m1  = (pgl_q != '0) ? pgl_q - 1'b1 : pgl_q;
    ids_sh  = {ids_q[15:0], item_i.miso_byte};
    lim12   = (op_q == OPN_PGM) ? pgm_to_q : ers_to_q;
    if (TickBits >= 12) limit = TickBits'(lim12);
    else if ((lim12 >> TickBits) != '0) limit = TickMax;
    else limit = TickBits'(lim12);
  end

  // page chunk: bytes from address a to the end of its page, capped at length r
  function automatic logic [PgW-1:0] chunk_of(logic [AddrBits-1:0] a, logic [15:0] r);
    logic [PgW-1:0] c;
    c = PgW'(PageBytes) - PgW'(a[PoW-1:0]);
    if (17'(c) > 17'(r)) c = PgW'(r);
    return c;
  endfunction

  always_comb begin
    ph_d = ph_q; op_d = op_q; addr_d = addr_q; rem_d = rem_q; pgl_d = pgl_q;
    fi_d = fi_q; tk_d = tk_q; ids_d = ids_q; cap_d = cap_q;
    res_o = '0;
    chunk_pg = chunk_of(a_in, item_i.length);
    case (item_i.command)
      CMD_READ, CMD_PGM, CMD_ERASE, CMD_ID: begin
        res_o.count = 2'd1;
        if (ph_q != PH_IDLE) begin
          res_o.r0 = mk(KIND_DONE, 8'h0, 8'h0, ST_REJECT, 24'h0);
        end else begin
          addr_d = a_in; rem_d = item_i.length; fi_d = '0;
          op_d = opn_e'(item_i.command[1:0]);
          case (item_i.command)
            CMD_READ: begin
              if (!rng_ok) res_o.r0 = mk(KIND_DONE, 8'h0, 8'h0, ST_REJECT, 24'h0);
              else if (item_i.length == '0) res_o.r0 = mk(KIND_DONE, 8'h0, 8'h0, ST_OK, 24'h0);
              else begin
                ph_d = PH_READ_HDR; res_o.r0 = mk(KIND_XFER, OP_READ, 8'h0, ST_OK, 24'h0);
              end
            end
            CMD_PGM: begin
              if (item_i.length == '0 || !rng_ok)
                res_o.r0 = mk(KIND_DONE, 8'h0, 8'h0, ST_REJECT, 24'h0);
              else begin
                pgl_d = chunk_pg; ph_d = PH_WREN;
                res_o.r0 = mk(KIND_XFER, OP_WREN, 8'h0, ST_OK, 24'h0);
              end
            end
            CMD_ERASE: begin
              if (!rng_ok) res_o.r0 = mk(KIND_DONE, 8'h0, 8'h0, ST_REJECT, 24'h0);
              else begin
                pgl_d = '0; ph_d = PH_WREN;
                res_o.r0 = mk(KIND_XFER, OP_WREN, 8'h0, ST_OK, 24'h0);
              end
            end
            default: begin
              if (!link_q) res_o.r0 = mk(KIND_DONE, 8'h0, 8'h0, ST_REJECT, 24'h0);
              else begin
                ids_d = '0; ph_d = PH_ID;
                res_o.r0 = mk(KIND_XFER, OP_RDID, 8'h0, ST_OK, 24'h0);
              end
            end
          endcase
        end
      end
      CMD_BYTE: begin
        if (ph_q == PH_PP_WAIT) begin
          ph_d = PH_PP_DATA; res_o.count = 2'd1;
          res_o.r0 = mk(KIND_XFER, item_i.data_byte, 8'h0, ST_OK, 24'h0);
        end
      end
      CMD_TICK: begin
        if ((ph_q == PH_POLL_CMD || ph_q == PH_POLL_STAT) && tk_q != TickMax)
          tk_d = tk_q + 1'b1;
      end
      CMD_REPLY: begin
        case (ph_q)
          PH_READ_HDR, PH_PP_HDR, PH_ER_HDR: begin
            fi_d = fi_p1; res_o.count = 2'd1;
            if (fi_p1 < 3'd4) res_o.r0 = mk(KIND_XFER, abyte, 8'h0, ST_OK, 24'h0);
            else if (ph_q == PH_READ_HDR) begin
              ph_d = PH_READ_DATA; res_o.r0 = mk(KIND_XFER, OP_DUMMY, 8'h0, ST_OK, 24'h0);
            end else if (ph_q == PH_PP_HDR) begin
              ph_d = PH_PP_WAIT; res_o.r0 = mk(KIND_DREQ, 8'h0, 8'h0, ST_OK, 24'h0);
            end else begin
              res_o.count = 2'd2; tk_d = '0; ph_d = PH_POLL_CMD;
              res_o.r0 = mk(KIND_CSREL, 8'h0, 8'h0, ST_OK, 24'h0);
              res_o.r1 = mk(KIND_XFER, OP_RDSR, 8'h0, ST_OK, 24'h0);
            end
          end
          PH_READ_DATA: begin
            rem_d = rem_m1;
            res_o.r0 = mk(KIND_RDATA, 8'h0, item_i.miso_byte, ST_OK, 24'h0);
            if (rem_m1 != '0) begin
              res_o.count = 2'd2; res_o.r1 = mk(KIND_XFER, OP_DUMMY, 8'h0, ST_OK, 24'h0);
            end else begin
              res_o.count = 2'd3; ph_d = PH_IDLE;
              res_o.r1 = mk(KIND_CSREL, 8'h0, 8'h0, ST_OK, 24'h0);
              res_o.r2 = mk(KIND_DONE, 8'h0, 8'h0, ST_OK, 24'h0);
            end
          end
          PH_ID: begin
            fi_d = fi_p1;
            if (fi_p1 >= 3'd2) ids_d = ids_sh;
            if (fi_p1 < 3'd4) begin
              res_o.count = 2'd1; res_o.r0 = mk(KIND_XFER, OP_DUMMY, 8'h0, ST_OK, 24'h0);
            end else begin
              cap_d = (ids_d[7:0] == DENSITY_4MIB) ? CAPACITY_4MIB : '0;
              res_o.count = 2'd2; ph_d = PH_IDLE;
              res_o.r0 = mk(KIND_CSREL, 8'h0, 8'h0, ST_OK, 24'h0);
              res_o.r1 = mk(KIND_DONE, 8'h0, 8'h0, ST_OK, ids_d);
            end
          end
          PH_WREN: begin
            fi_d = '0; res_o.count = 2'd2;
            res_o.r0 = mk(KIND_CSREL, 8'h0, 8'h0, ST_OK, 24'h0);
            if (op_q == OPN_PGM) begin
              ph_d = PH_PP_HDR; res_o.r1 = mk(KIND_XFER, OP_PP, 8'h0, ST_OK, 24'h0);
            end else begin
              ph_d = PH_ER_HDR; res_o.r1 = mk(KIND_XFER, OP_SE, 8'h0, ST_OK, 24'h0);
            end
          end
          PH_PP_DATA: begin
            pgl_d = pgl_m1; rem_d = rem_m1; addr_d = cur_p1;
            if (pgl_m1 != '0 && rem_m1 != '0) begin
              ph_d = PH_PP_WAIT; res_o.count = 2'd1;
              res_o.r0 = mk(KIND_DREQ, 8'h0, 8'h0, ST_OK, 24'h0);
            end else begin
              res_o.count = 2'd2; tk_d = '0; ph_d = PH_POLL_CMD;
              res_o.r0 = mk(KIND_CSREL, 8'h0, 8'h0, ST_OK, 24'h0);
              res_o.r1 = mk(KIND_XFER, OP_RDSR, 8'h0, ST_OK, 24'h0);
            end
          end
          PH_POLL_CMD: begin
            ph_d = PH_POLL_STAT; res_o.count = 2'd1;
            res_o.r0 = mk(KIND_XFER, OP_DUMMY, 8'h0, ST_OK, 24'h0);
          end
          PH_POLL_STAT: begin
            res_o.count = 2'd2;
            res_o.r0 = mk(KIND_CSREL, 8'h0, 8'h0, ST_OK, 24'h0);
            if (!item_i.miso_byte[0]) begin
              if (op_q == OPN_PGM && rem_q != '0) begin
                pgl_d = chunk_of(addr_q, rem_q); fi_d = '0; ph_d = PH_WREN;
                res_o.r1 = mk(KIND_XFER, OP_WREN, 8'h0, ST_OK, 24'h0);
              end else begin
                ph_d = PH_IDLE; res_o.r1 = mk(KIND_DONE, 8'h0, 8'h0, ST_OK, 24'h0);
              end
            end else if (tk_q >= limit) begin
              ph_d = PH_IDLE; res_o.r1 = mk(KIND_DONE, 8'h0, 8'h0, ST_TIMEOUT, 24'h0);
            end else begin
              ph_d = PH_POLL_CMD; res_o.r1 = mk(KIND_XFER, OP_RDSR, 8'h0, ST_OK, 24'h0);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // flag the final word of this set
    case (res_o.count)
      2'd1: res_o.r0.last = 1'b1;
      2'd2: res_o.r1.last = 1'b1;
      2'd3: res_o.r2.last = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== sv/snor_outq.sv =====
module snor_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  snor_pkg::res_set_t  set_i,
  output logic                can_load_o,
  output logic                valid_o,
  input  logic                stall_i,
  output snor_pkg::out_word_t data_o
);
  import snor_pkg::*;

  // two result-set slots, drained one word per cycle unless stall_i is high
  res_set_t   slot_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic [1:0] pos_q;
  logic       pop_word, pop_set;

  assign valid_o    = cnt_q != 2'd0;
  assign can_load_o = cnt_q != 2'd2 || pop_set;
  assign pop_word   = valid_o && !stall_i;
  assign pop_set    = pop_word && (pos_q == slot_q[rd_q].count - 2'd1);

  always_comb begin
    case (pos_q)
      2'd0:    data_o = slot_q[rd_q].r0;
      2'd1:    data_o = slot_q[rd_q].r1;
      default: data_o = slot_q[rd_q].r2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) slot_q[wr_q] <= set_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; pos_q <= '0;
    end else begin
      if (load_i) wr_q <= !wr_q;
      if (pop_set) begin
        rd_q <= !rd_q; pos_q <= '0;
      end else if (pop_word) begin
        pos_q <= pos_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, load_i} - {1'b0, pop_set};
    end
  end
endmodule

// ===== sv/spi_nor_command_sequencer_unit.sv =====
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid_i/stall_o | snor_pkg::in_word_t
// out     | output    | out_valid_o/stall_i| snor_pkg::out_word_t
// cfg     | input     | cfg_we_i           | cfg_idx_i, cfg_data_i
// One input word is taken per cycle; its zero to three results are computed in
// that cycle, queued in a two-set output buffer; one leaves per unstalled cycle.
// Input stalls only when both buffer sets are full and none drains this cycle.
// Reset is asynchronous: sequencer idle, no device known, registers at defaults.
module spi_nor_command_sequencer_unit #(
  parameter int unsigned PageBytes   = snor_pkg::PageBytesDef,
  parameter int unsigned SectorBytes = snor_pkg::SectorBytesDef,
  parameter int unsigned AddrBits    = snor_pkg::AddrBitsDef,
  parameter int unsigned TickBits    = snor_pkg::TickBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [11:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  snor_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output snor_pkg::out_word_t out_data_o
);
  import snor_pkg::*;

  res_set_t set;
  logic     can_load, take;

  assign in_stall_o = !can_load;
  assign take       = in_valid_i && can_load;

  snor_core #(
    .PageBytes(PageBytes), .SectorBytes(SectorBytes),
    .AddrBits(AddrBits), .TickBits(TickBits)
  ) u_core (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .step_i(take), .item_i(in_data_i), .res_o(set)
  );

  // queue only sets that hold results
  snor_outq u_outq (
    .clk_i, .rst_ni,
    .load_i(take && set.count != 2'd0), .set_i(set),
    .can_load_o(can_load), .valid_o(out_valid_o), .stall_i(out_stall_i),
    .data_o(out_data_o)
  );
endmodule

// ===== test/tb_spi_nor_command_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_spi_nor_command_sequencer_unit;
  import snor_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TargetWords = 460;

  // Expected-word tracker: mirrors the sequencer state and queues its replies
  class flash_scoreboard;
    bit         link_en;
    bit [11:0]  pgm_limit;
    bit [11:0]  ers_limit;
    phase_e     ph;
    opn_e       opn;
    bit [23:0]  cur_addr;
    bit [15:0]  remain;
    bit [9:0]   page_left;
    bit [2:0]   frame;
    bit [11:0]  ticks;
    bit [23:0]  id_acc;
    bit [22:0]  capacity;
    out_word_t  pending_words[$];
    out_word_t  batch[$];
    int         errors;

    function new();
      link_en   = 1'b0;
      pgm_limit = 12'd500;
      ers_limit = 12'd3000;
      ph        = PH_IDLE;
      opn       = OPN_READ;
      cur_addr  = '0;
      remain    = '0;
      page_left = '0;
      frame     = '0;
      ticks     = '0;
      id_acc    = '0;
      capacity  = '0;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [11:0] val);
      case (idx)
        CFG_LINK:   link_en = val[0];
        CFG_PGM_TO: pgm_limit = val;
        CFG_ERS_TO: ers_limit = val;
        default: ;
      endcase
    endfunction

    function void emit(kind_e k, logic [7:0] mo = 8'h00, logic [7:0] rd = 8'h00,
                       logic [1:0] st = ST_OK, logic [23:0] id = 24'h0);
      out_word_t r;
      r.kind = k;
      r.mosi_byte = mo;
      r.read_byte = rd;
      r.status = st;
      r.id_value = id;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void complete(logic [1:0] st, logic [23:0] id);
      emit(KIND_DONE, 8'h00, 8'h00, st, id);
      ph = PH_IDLE;
    endfunction

    function bit in_range(bit [23:0] a, int unsigned len);
      return link_en && capacity != 0 && a <= capacity && len <= capacity - a;
    endfunction

    function logic [7:0] addr_byte(bit [2:0] f);
      return 8'(cur_addr >> (8 * (3 - f)));
    endfunction

    function void start_page();
      int unsigned chunk;
      chunk = 256 - (cur_addr % 256);
      if (chunk > remain) chunk = remain;
      page_left = 10'(chunk);
      frame = '0;
      ph = PH_WREN;
      emit(KIND_XFER, OP_WREN);
    endfunction

    function void send_poll();
      ph = PH_POLL_CMD;
      emit(KIND_XFER, OP_RDSR);
    endfunction

    function void take_request(in_word_t w);
      if (ph != PH_IDLE) begin
        emit(KIND_DONE, 8'h00, 8'h00, ST_REJECT);
        return;
      end
      cur_addr = w.address;
      remain = w.length;
      frame = '0;
      opn = opn_e'(w.command[1:0]);
      case (opn)
        OPN_READ: begin
          if (!in_range(w.address, w.length)) complete(ST_REJECT, '0);
          else if (w.length == 0) complete(ST_OK, '0);
          else begin
            ph = PH_READ_HDR;
            emit(KIND_XFER, OP_READ);
          end
        end
        OPN_PGM: begin
          if (w.length == 0 || !in_range(w.address, w.length)) complete(ST_REJECT, '0);
          else start_page();
        end
        OPN_ERASE: begin
          if (!in_range({w.address[23:12], 12'h000}, 4096)) complete(ST_REJECT, '0);
          else begin
            page_left = '0;
            ph = PH_WREN;
            emit(KIND_XFER, OP_WREN);
          end
        end
        default: begin
          if (!link_en) complete(ST_REJECT, '0);
          else begin
            id_acc = '0;
            ph = PH_ID;
            emit(KIND_XFER, OP_RDID);
          end
        end
      endcase
    endfunction

    function void take_reply(logic [7:0] miso);
      bit [11:0] limit;
      case (ph)
        PH_READ_HDR: begin
          frame++;
          if (frame < 4) emit(KIND_XFER, addr_byte(frame));
          else begin
            ph = PH_READ_DATA;
            emit(KIND_XFER, OP_DUMMY);
          end
        end
        PH_READ_DATA: begin
          emit(KIND_RDATA, 8'h00, miso);
          remain--;
          if (remain != 0) emit(KIND_XFER, OP_DUMMY);
          else begin
            emit(KIND_CSREL);
            complete(ST_OK, '0);
          end
        end
        PH_ID: begin
          frame++;
          if (frame >= 2) id_acc = {id_acc[15:0], miso};
          if (frame < 4) emit(KIND_XFER, OP_DUMMY);
          else begin
            capacity = (id_acc[7:0] == DENSITY_4MIB) ? CAPACITY_4MIB : '0;
            emit(KIND_CSREL);
            complete(ST_OK, id_acc);
          end
        end
        PH_WREN: begin
          emit(KIND_CSREL);
          frame = '0;
          if (opn == OPN_PGM) begin
            ph = PH_PP_HDR;
            emit(KIND_XFER, OP_PP);
          end else begin
            ph = PH_ER_HDR;
            emit(KIND_XFER, OP_SE);
          end
        end
        PH_PP_HDR: begin
          frame++;
          if (frame < 4) emit(KIND_XFER, addr_byte(frame));
          else begin
            ph = PH_PP_WAIT;
            emit(KIND_DREQ);
          end
        end
        PH_ER_HDR: begin
          frame++;
          if (frame < 4) emit(KIND_XFER, addr_byte(frame));
          else begin
            emit(KIND_CSREL);
            ticks = '0;
            send_poll();
          end
        end
        PH_PP_DATA: begin
          if (page_left != 0) page_left--;
          remain--;
          cur_addr++;
          if (page_left != 0 && remain != 0) begin
            ph = PH_PP_WAIT;
            emit(KIND_DREQ);
          end else begin
            emit(KIND_CSREL);
            ticks = '0;
            send_poll();
          end
        end
        PH_POLL_CMD: begin
          ph = PH_POLL_STAT;
          emit(KIND_XFER, OP_DUMMY);
        end
        PH_POLL_STAT: begin
          emit(KIND_CSREL);
          limit = (opn == OPN_PGM) ? pgm_limit : ers_limit;
          if (!miso[0]) begin
            if (opn == OPN_PGM && remain != 0) start_page();
            else complete(ST_OK, '0);
          end else if (ticks >= limit) complete(ST_TIMEOUT, '0);
          else send_poll();
        end
        default: ;
      endcase
    endfunction

    // Note an accepted input word and queue the words it causes
    function void note_input(in_word_t w);
      batch.delete();
      case (w.command)
        CMD_READ, CMD_PGM, CMD_ERASE, CMD_ID: take_request(w);
        CMD_BYTE: begin
          if (ph == PH_PP_WAIT) begin
            ph = PH_PP_DATA;
            emit(KIND_XFER, w.data_byte);
          end
        end
        CMD_REPLY: take_reply(w.miso_byte);
        CMD_TICK: begin
          if ((ph == PH_POLL_CMD || ph == PH_POLL_STAT) && ticks != 12'hFFF) ticks++;
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_words.push_back(batch[i]);
    endfunction

    // Compare one output word with the oldest expected word
    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.kind !== exp_w.kind) begin
        $error("kind: expected %0d, got %0d", exp_w.kind, got.kind);
        errors++;
      end
      if (got.mosi_byte !== exp_w.mosi_byte) begin
        $error("mosi_byte: expected %h, got %h", exp_w.mosi_byte, got.mosi_byte);
        errors++;
      end
      if (got.read_byte !== exp_w.read_byte) begin
        $error("read_byte: expected %h, got %h", exp_w.read_byte, got.read_byte);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.id_value !== exp_w.id_value) begin
        $error("id_value: expected %h, got %h", exp_w.id_value, got.id_value);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_LINK;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;

  flash_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;

  spi_nor_command_sequencer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_spi_nor_command_sequencer_unit: errors");
      $finish;
    end
  end

  // Drain output words; stall at random or for a requested long hold
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_gaps && ($urandom % 100 < 24);
    end
  end

  function automatic in_word_t mk_word(cmd_e c, logic [23:0] a, logic [15:0] len,
                                       logic [7:0] db, logic [7:0] mi);
    in_word_t w;
    w.command = c;
    w.address = a;
    w.length = len;
    w.data_byte = db;
    w.miso_byte = mi;
    return w;
  endfunction

  function automatic in_word_t junk_word(int unsigned lo_cmd);
    in_word_t w;
    w.command = 3'($urandom_range(lo_cmd, 7));
    w.address = 24'($urandom);
    w.length = 16'($urandom);
    w.data_byte = 8'($urandom);
    w.miso_byte = 8'($urandom);
    return w;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send(in_word_t w);
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(w);
    words_sent++;
    if (tx_gaps && ($urandom % 100 < 24)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stop offering words until every expected word is out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_regs(bit link, logic [11:0] pto, logic [11:0] eto);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LINK;
    cfg_data_i <= {11'h0, link};
    @(posedge clk_i);
    sb.write_reg(CFG_LINK, {11'h0, link});
    cfg_idx_i <= CFG_PGM_TO;
    cfg_data_i <= pto;
    @(posedge clk_i);
    sb.write_reg(CFG_PGM_TO, pto);
    cfg_idx_i <= CFG_ERS_TO;
    cfg_data_i <= eto;
    @(posedge clk_i);
    sb.write_reg(CFG_ERS_TO, eto);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Issue a request, then play host and flash until the sequencer is idle
  task automatic run_txn(cmd_e c, logic [23:0] a, logic [15:0] len, logic [7:0] density,
                         int unsigned busy_pct);
    logic [7:0] mi;
    send(mk_word(c, a, len, 8'($urandom), 8'($urandom)));
    while (sb.ph != PH_IDLE) begin
      if ($urandom % 100 < 4) send(junk_word(0));
      else if (sb.ph == PH_PP_WAIT)
        send(mk_word(CMD_BYTE, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)));
      else if ((sb.ph == PH_POLL_CMD || sb.ph == PH_POLL_STAT) && ($urandom % 100 < 35))
        send(mk_word(CMD_TICK, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)));
      else begin
        mi = 8'($urandom);
        if (sb.ph == PH_ID && sb.frame == 3) mi = density;
        if (sb.ph == PH_POLL_STAT) mi[0] = ($urandom % 100 < busy_pct);
        send(mk_word(CMD_REPLY, 24'($urandom), 16'($urandom), 8'($urandom), mi));
      end
    end
  endtask

  task automatic random_txn();
    int unsigned pick;
    logic [23:0] a;
    logic [15:0] len;
    cmd_e c;
    pick = $urandom % 100;
    if (pick < 8) begin
      send(junk_word(4));
      return;
    end
    c = (pick < 38) ? CMD_READ : (pick < 70) ? CMD_PGM : (pick < 88) ? CMD_ERASE : CMD_ID;
    case ($urandom % 4)
      0: a = 24'($urandom_range(0, 24'h3FFFFF));
      1: a = 24'($urandom_range(24'h3FFFF0, 24'h400010));
      2: a = 24'(($urandom_range(0, 16'h3FFF) << 8) + $urandom_range(248, 255));
      default: a = 24'($urandom);
    endcase
    pick = $urandom % 100;
    if (pick < 4) len = 16'($urandom_range(20, 40));
    else if (pick < 8) begin
      len = 16'($urandom);
      a = 24'($urandom_range(24'h400000, 24'hFFFFFF));
    end else len = 16'($urandom_range(0, 12));
    run_txn(c, a, len, ($urandom % 100 < 85) ? DENSITY_4MIB : 8'($urandom), 50);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Link down at reset: every request is rejected, stray words are dropped
    run_txn(CMD_READ, 24'h000000, 16'd4, DENSITY_4MIB, 50);
    run_txn(CMD_ID, 24'h000000, 16'd0, DENSITY_4MIB, 50);
    send(mk_word(CMD_BYTE, 24'h0, 16'h0, 8'hA5, 8'h00));
    send(mk_word(CMD_REPLY, 24'h0, 16'h0, 8'h00, 8'hFF));
    send(mk_word(CMD_TICK, 24'h0, 16'h0, 8'h00, 8'h00));
    send(mk_word(cmd_e'(3'd7), 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF));

    set_regs(1'b1, 12'd4095, 12'd4095);
    // Unknown density leaves no device, so a read fails
    run_txn(CMD_ID, 24'h0, 16'h0, 8'h17, 50);
    run_txn(CMD_READ, 24'h0, 16'd1, DENSITY_4MIB, 50);
    run_txn(CMD_ID, 24'h0, 16'h0, DENSITY_4MIB, 50);
    run_txn(CMD_READ, 24'h001234, 16'd0, DENSITY_4MIB, 50);
    run_txn(CMD_READ, 24'h3FFFFF, 16'd1, DENSITY_4MIB, 50);
    run_txn(CMD_READ, 24'h400000, 16'd0, DENSITY_4MIB, 50);
    run_txn(CMD_READ, 24'h400000, 16'd1, DENSITY_4MIB, 50);
    run_txn(CMD_READ, 24'hFFFFFF, 16'hFFFF, DENSITY_4MIB, 50);
    run_txn(CMD_PGM, 24'h000010, 16'd0, DENSITY_4MIB, 50);
    run_txn(CMD_PGM, 24'h0000FE, 16'd4, DENSITY_4MIB, 60);
    run_txn(CMD_ERASE, 24'h3FFABC, 16'd0, DENSITY_4MIB, 60);
    run_txn(CMD_ERASE, 24'h400000, 16'd0, DENSITY_4MIB, 60);
    // Requests arriving mid-program are rejected while the program goes on
    send(mk_word(CMD_PGM, 24'h000100, 16'd2, 8'h00, 8'h00));
    send(mk_word(CMD_READ, 24'h0, 16'd1, 8'h00, 8'h00));
    send(mk_word(CMD_ERASE, 24'h0, 16'd0, 8'h00, 8'h00));
    send(mk_word(CMD_ID, 24'h0, 16'd0, 8'h00, 8'h00));
    run_txn(CMD_PGM, 24'h0, 16'd1, DENSITY_4MIB, 50);

    // Tiny limits: timeouts become reachable
    set_regs(1'b1, 12'd1, 12'd1);
    run_txn(CMD_PGM, 24'h0002F0, 16'd3, DENSITY_4MIB, 90);
    run_txn(CMD_ERASE, 24'h001000, 16'd0, DENSITY_4MIB, 90);
    while (words_sent < 120) random_txn();

    // Long stretch with no idling on either side
    set_regs(1'b1, 12'd4095, 12'd4095);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_txn(CMD_PGM, 24'h0010F8, 16'd20, DENSITY_4MIB, 40);
    while (words_sent < 260) random_txn();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // Receiver holds off while words keep coming
    set_regs(1'b1, 12'($urandom_range(1, 6)), 12'($urandom_range(1, 6)));
    hold_asked++;
    while (words_sent < 340) random_txn();
    drain();

    // Link cleared in the middle of an operation
    set_regs(1'b1, 12'd3, 12'd5);
    send(mk_word(CMD_ERASE, 24'h002000, 16'd0, 8'h00, 8'h00));
    set_regs(1'b0, 12'd3, 12'd5);
    while (sb.ph != PH_IDLE) random_txn();
    repeat (6) random_txn();

    set_regs(1'b1, 12'($urandom_range(1, 8)), 12'($urandom_range(1, 8)));
    run_txn(CMD_ID, 24'h0, 16'h0, DENSITY_4MIB, 50);
    while (words_sent < TargetWords) random_txn();

    drain();
    in_valid_i <= 1'b0;
    repeat (20) @(posedge clk_i);
    if (sb.pending_words.size() != 0) begin
      $error("%0d expected words never arrived", sb.pending_words.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_spi_nor_command_sequencer_unit: clean");
    end else begin
      $display("tb_spi_nor_command_sequencer_unit: errors");
    end
    $finish;
  end

endmodule
